// File: rtl/cidr_pkg.sv
// Shared types, widths and helpers for the IPv4 range to CIDR cover block.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package cidr_pkg;

  localparam int ADDR_W              = 32;
  localparam int REM_W               = ADDR_W + 1;
  localparam int PREFIX_W            = 6;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [PREFIX_W-1:0] FULL_PREFIX = PREFIX_W'(ADDR_W);

  typedef struct packed {
    logic [ADDR_W-1:0] cursor;
    logic [REM_W-1:0]  remain;
  } range_t;

  typedef struct packed {
    logic   valid;
    range_t item;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic logic [PREFIX_W-1:0] onehot_index(input logic [REM_W-1:0] oh);
    logic [PREFIX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < REM_W; i++) begin
      if (oh[i]) begin
        idx = idx | PREFIX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/cidr_front.sv
// Front end: takes range beats, drops empty ranges and works out the address count.
// Depends on cidr_pkg.
`timescale 1ns / 1ps

module cidr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cidr_pkg::ADDR_W-1:0]  range_start,
  input  logic [cidr_pkg::ADDR_W-1:0]  range_end,
  input  cidr_pkg::queue_status_t      status,
  output logic                         busy,
  output cidr_pkg::push_t              push
);

  logic                         held;
  cidr_pkg::range_t             held_item;
  logic                         accept;
  logic                         nonempty;
  logic [cidr_pkg::REM_W-1:0]   count_addr;

  assign busy       = held & status.full;
  assign accept     = start & ~busy;
  assign nonempty   = range_start <= range_end;
  assign count_addr = {1'b0, range_end} - {1'b0, range_start} + cidr_pkg::REM_W'(1);

  assign push.valid = held & ~status.full;
  assign push.item  = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= nonempty;
    end else if (push.valid) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item.cursor <= range_start;
      held_item.remain <= count_addr;
    end
  end

endmodule

// File: rtl/cidr_fifo.sv
// Short register queue between the front end and the splitter.
// Depends on cidr_pkg.
`timescale 1ns / 1ps

module cidr_fifo #(
  parameter int DEPTH = cidr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cidr_pkg::push_t         push,
  input  logic                    pop,
  output cidr_pkg::range_t        head,
  output cidr_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cidr_pkg::range_t   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign status.full  = count == CNT_W'(DEPTH);
  assign status.empty = count == '0;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !status.full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

// File: rtl/cidr_back.sv
// Splitter: emits one aligned CIDR block per cycle for the range at the queue head.
// Depends on cidr_pkg.
`timescale 1ns / 1ps

module cidr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  cidr_pkg::queue_status_t        status,
  input  cidr_pkg::range_t               head,
  output logic                           pop,
  output logic                           strobe,
  output logic [cidr_pkg::ADDR_W-1:0]    block_base,
  output logic [cidr_pkg::PREFIX_W-1:0]  prefix_length,
  output logic                           last_block
);

  logic                        active;
  logic [cidr_pkg::ADDR_W-1:0] cursor;
  logic [cidr_pkg::REM_W-1:0]  remain;

  logic [cidr_pkg::REM_W-1:0]  ext_cursor;
  logic [cidr_pkg::REM_W-1:0]  low_bit;
  logic [cidr_pkg::REM_W-1:0]  smear;
  logic [cidr_pkg::REM_W-1:0]  high_bit;
  logic [cidr_pkg::REM_W-1:0]  size;
  logic                        last_step;
  logic [cidr_pkg::ADDR_W-1:0] cursor_next;
  logic [cidr_pkg::REM_W-1:0]  remain_next;

  // A cursor of zero is aligned to the whole address space.
  assign ext_cursor = {cursor == '0, cursor};
  assign low_bit    = ext_cursor & (~ext_cursor + cidr_pkg::REM_W'(1));

  always_comb begin
    smear = remain;
    for (int k = 1; k < cidr_pkg::REM_W; k = k * 2) begin
      smear = smear | (smear >> k);
    end
  end

  assign high_bit    = smear ^ (smear >> 1);
  assign size        = (low_bit < high_bit) ? low_bit : high_bit;
  assign last_step   = remain == size;
  assign cursor_next = cursor + size[cidr_pkg::ADDR_W-1:0];
  assign remain_next = remain - size;
  assign pop         = ~status.empty & (~active | last_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (last_step) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cursor <= head.cursor;
      remain <= head.remain;
    end else if (active) begin
      cursor <= cursor_next;
      remain <= remain_next;
    end
    block_base    <= cursor;
    prefix_length <= cidr_pkg::FULL_PREFIX - cidr_pkg::onehot_index(size);
    last_block    <= last_step;
  end

  a_remain_live: assert property (@(posedge clk) disable iff (rst)
    active |-> remain != '0) else $error("splitter active with nothing left");
  a_size_onehot: assert property (@(posedge clk) disable iff (rst)
    active |-> $onehot(size)) else $error("block size not a power of two");
  a_size_fits: assert property (@(posedge clk) disable iff (rst)
    active |-> size <= remain) else $error("block passes the end of the range");
  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> prefix_length <= cidr_pkg::FULL_PREFIX) else $error("prefix too long");

endmodule

// File: rtl/ipv4_range_to_cidr_cover.sv
// Top level of the IPv4 range to CIDR cover block: front end, queue and splitter.
// Depends on cidr_pkg, cidr_front, cidr_fifo and cidr_back.
// A taken beat is registered in the front end, then in the queue, then in the splitter, and each
// block is registered onto the result ports. A range of N blocks (1 to 62) gives one block per
// cycle; queued ranges follow each other in the splitter without a gap. Empty ranges emit nothing.
// Synchronous reset empties the queue and idles both halves; results cannot be held off.
`timescale 1ns / 1ps

module ipv4_range_to_cidr_cover #(
  parameter int QUEUE_DEPTH = cidr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [cidr_pkg::ADDR_W-1:0]    range_start,
  input  logic [cidr_pkg::ADDR_W-1:0]    range_end,
  output logic                           strobe,
  output logic [cidr_pkg::ADDR_W-1:0]    block_base,
  output logic [cidr_pkg::PREFIX_W-1:0]  prefix_length,
  output logic                           last_block
);

  cidr_pkg::push_t         push;
  cidr_pkg::queue_status_t status;
  cidr_pkg::range_t        head;
  logic                    pop;

  cidr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .range_start (range_start),
    .range_end   (range_end),
    .status      (status),
    .busy        (busy),
    .push        (push)
  );

  cidr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  cidr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .status        (status),
    .head          (head),
    .pop           (pop),
    .strobe        (strobe),
    .block_base    (block_base),
    .prefix_length (prefix_length),
    .last_block    (last_block)
  );

endmodule
